[rtl/sha512_pkg.sv]
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, constants and the rotate helper of the SHA-512 hash core.
// ----------------------------------------------------------------------------
package sha512_pkg;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned LEN_POS = 112;
	localparam logic [7:0] PAD_BYTE = 8'h80;

	typedef logic [63:0] word_t;

	// commands from controller to datapath
	typedef struct packed {
		logic put;        // write put_val at byte_pos
		logic [7:0] put_val;
		logic clr_block;  // zero the whole block
		logic put_len;    // words 14,15 get zero and bit count
		logic add_bits;   // bit count += 8
		logic start;      // load working vars and window
		logic round;      // one round step
		logic fold;       // chain += working vars
		logic init;       // chain and bit count back to initial values
		logic [6:0] round_idx;
		logic [2:0] out_idx;
	} cmd_t;

	localparam word_t INIT_H [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
		64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
		64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam word_t ROUND_K [ROUNDS] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction

endpackage

[rtl/sha512_datapath.sv]
// ----------------------------------------------------------------------------
// sha512_datapath
// Block buffer, schedule window, round unit and chaining value.
// ----------------------------------------------------------------------------
module sha512_datapath (
	input  logic clk,
	input  logic arst_n,
	input  sha512_pkg::cmd_t cmd,
	input  logic [6:0] byte_pos,
	output sha512_pkg::word_t digest
);
	import sha512_pkg::*;

	word_t block_q [16];
	word_t win_q [16];
	word_t var_q [8];
	word_t chain_q [8];
	word_t bits_q;

	word_t w_cur, s1, ch, t1, s0, mj, x, y, w_new;

	always_comb begin
		x = win_q[1];
		y = win_q[14];
		w_new = win_q[0] + (rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7)) + win_q[9]
			+ (rotr(y, 19) ^ rotr(y, 61) ^ (y >> 6));
		// window shifts each round, so slot 0 always holds word i
		w_cur = win_q[0];
		s1 = rotr(var_q[4], 14) ^ rotr(var_q[4], 18) ^ rotr(var_q[4], 41);
		ch = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
		t1 = var_q[7] + s1 + ch + ROUND_K[cmd.round_idx] + w_cur;
		s0 = rotr(var_q[0], 28) ^ rotr(var_q[0], 34) ^ rotr(var_q[0], 39);
		mj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_block) begin
			for (int i = 0; i < 16; i++) block_q[i] <= '0;
		end else if (cmd.put) begin
			block_q[byte_pos[6:3]][8*(7-byte_pos[2:0]) +: 8] <= cmd.put_val;
		end
		if (cmd.put_len) begin
			block_q[14] <= '0;
			block_q[15] <= bits_q;
		end
		if (cmd.start) begin
			for (int i = 0; i < 16; i++) win_q[i] <= block_q[i];
			for (int i = 0; i < 8; i++) var_q[i] <= chain_q[i];
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
			win_q[15] <= w_new;
			var_q[7] <= var_q[6];
			var_q[6] <= var_q[5];
			var_q[5] <= var_q[4];
			var_q[4] <= var_q[3] + t1;
			var_q[3] <= var_q[2];
			var_q[2] <= var_q[1];
			var_q[1] <= var_q[0];
			var_q[0] <= t1 + s0 + mj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= INIT_H[i];
			bits_q <= '0;
		end else if (cmd.init) begin
			for (int i = 0; i < 8; i++) chain_q[i] <= INIT_H[i];
			bits_q <= '0;
		end else begin
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + var_q[i];
			end
			if (cmd.add_bits) bits_q <= bits_q + 64'd8;
		end
	end

	assign digest = chain_q[cmd.out_idx];

endmodule

[rtl/sha512_ctrl.sv]
// ----------------------------------------------------------------------------
// sha512_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha512_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic has_byte,
	input  logic end_of_message,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] word_number,
	output logic last_word,
	output logic [6:0] byte_pos,
	output sha512_pkg::cmd_t cmd
);
	import sha512_pkg::*;

	typedef enum logic [2:0] {IDLE, PAD, LEN, START, ROUND, FOLD, EMIT} state_t;

	state_t state_q;
	logic [6:0] pos_q;
	logic [6:0] rnd_q;
	logic [2:0] out_q;
	logic end_q;      // message end pending
	logic final_q;    // block being compressed is the last one
	logic extra_q;    // pad went past the length field, a length-only block follows

	assign in_ready = (state_q == IDLE);
	assign out_valid = (state_q == EMIT);
	assign word_number = out_q;
	assign last_word = (out_q == 3'd7);
	assign byte_pos = pos_q;

	logic acc;
	assign acc = in_valid && in_ready;

	// pad byte lands inside the length field
	logic pad_late;
	assign pad_late = end_q && (pos_q >= 7'(LEN_POS));

	always_comb begin
		cmd = '0;
		cmd.round_idx = rnd_q;
		cmd.out_idx = out_q;
		unique case (state_q)
			IDLE: begin
				cmd.put = acc && has_byte;
				cmd.put_val = data_byte;
				cmd.add_bits = acc && has_byte;
			end
			PAD: begin
				cmd.put = 1'b1;
				cmd.put_val = end_q ? PAD_BYTE : 8'h00;
			end
			LEN: begin
				cmd.put_len = 1'b1;
			end
			START: cmd.start = 1'b1;
			ROUND: cmd.round = 1'b1;
			FOLD: begin
				cmd.fold = 1'b1;
				cmd.clr_block = 1'b1;
			end
			EMIT: cmd.init = out_valid && out_ready && last_word;
			default: ;
		endcase
	end

	// pad writes 0x80 at pos, then zeros one a cycle up to the end of the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			pos_q <= '0;
			rnd_q <= '0;
			out_q <= '0;
			end_q <= 1'b0;
			final_q <= 1'b0;
			extra_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: if (acc) begin
					end_q <= end_of_message;
					if (has_byte) begin
						pos_q <= pos_q + 7'd1;
						if (pos_q == 7'd127) begin
							final_q <= 1'b0;
							state_q <= START;
						end else if (end_of_message) begin
							state_q <= PAD;
						end
					end else if (end_of_message) begin
						state_q <= PAD;
					end
				end
				PAD: begin
					// first pad cycle writes 0x80, rest write zeros up to the end
					end_q <= 1'b0;
					pos_q <= pos_q + 7'd1;
					if (pad_late) extra_q <= 1'b1;
					if (pos_q == 7'd127) begin
						if (extra_q || pad_late) begin
							final_q <= 1'b0;
							state_q <= START;
						end else begin
							state_q <= LEN;
						end
					end
				end
				LEN: begin
					final_q <= 1'b1;
					state_q <= START;
				end
				START: begin
					rnd_q <= '0;
					state_q <= ROUND;
				end
				ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(ROUNDS - 1)) state_q <= FOLD;
				end
				FOLD: begin
					if (end_q) begin
						// block filled by a byte that also ended the message
						state_q <= PAD;
						pos_q <= '0;
					end else if (extra_q) begin
						// block was just cleared, only the length goes in
						extra_q <= 1'b0;
						state_q <= LEN;
					end else if (final_q) begin
						out_q <= '0;
						state_q <= EMIT;
					end else begin
						state_q <= IDLE;
					end
				end
				EMIT: if (out_ready) begin
					out_q <= out_q + 3'd1;
					if (last_word) begin
						pos_q <= '0;
						final_q <= 1'b0;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule

[rtl/sha512_hash_core.sv]
// ----------------------------------------------------------------------------
// sha512_hash_core
// SHA-512 digest of a byte stream, at most one byte per item.
// ----------------------------------------------------------------------------
// A byte item is taken while the core is idle. A full 128-byte block then
// holds the input while the single round unit runs 80 rounds. On the end
// item the block is padded one byte a cycle up to its end, the length is
// placed, and a second block is run first if the pad pushed past byte 111.
// Eight digest words follow, H0 first, one per output handshake.
module sha512_hash_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic has_byte,
	input  logic end_of_message,
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] digest_word,
	output logic [2:0] word_number,
	output logic last_word
);
	import sha512_pkg::*;

	cmd_t cmd;
	logic [6:0] byte_pos;

	sha512_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .data_byte, .has_byte,
		.end_of_message, .out_valid, .out_ready, .word_number, .last_word,
		.byte_pos, .cmd
	);

	sha512_datapath u_dp (
		.clk, .arst_n, .cmd, .byte_pos, .digest(digest_word)
	);

endmodule

[rtl/sha512_checker.sv]
// ----------------------------------------------------------------------------
// sha512_checker
// Port-level checks of the SHA-512 hash core.
// ----------------------------------------------------------------------------
module sha512_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [2:0] word_number,
	input logic last_word
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open while emitting");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_number == 3'd7))) else $error("last flag");
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_word) |=> (out_valid &&
		word_number == $past(word_number) + 3'd1)) else $error("word order");
endmodule

bind sha512_hash_core sha512_checker u_chk (.*);

[tb/sv/sha512_digest_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha512_digest_checker
// Watches both channels of the hash core, hashes each accepted message
// with a software SHA-512 and compares every digest word against it.
// ----------------------------------------------------------------------------
module sha512_digest_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [7:0] data_byte,
	input  logic has_byte,
	input  logic end_of_message,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [63:0] digest_word,
	input  logic [2:0] word_number,
	input  logic last_word,
	output int errors,
	output int pending
);
	import sha512_pkg::*;

	typedef struct packed {
		logic [63:0] word;
		logic [2:0] num;
		logic last;
	} digest_item_t;

	digest_item_t digest_queue[$];
	word_t chain [8];
	word_t blk [16];
	logic [63:0] bit_count;
	int unsigned byte_pos;

	function automatic word_t ror(word_t x, int unsigned n);
		return (x >> n) | (x << (64 - n));
	endfunction

	task automatic compress();
		word_t w [16];
		word_t v [8];
		word_t x, t1, t2, wi;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		for (int i = 0; i < 8; i++) v[i] = chain[i];
		for (int i = 0; i < 80; i++) begin
			if (i < 16) begin
				wi = w[i];
			end else begin
				x = w[(i - 15) & 15];
				wi = w[i & 15] + (ror(x, 1) ^ ror(x, 8) ^ (x >> 7)) + w[(i - 7) & 15];
				x = w[(i - 2) & 15];
				wi = wi + (ror(x, 19) ^ ror(x, 61) ^ (x >> 6));
				w[i & 15] = wi;
			end
			t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + wi;
			t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			for (int j = 7; j > 0; j--) v[j] = v[j - 1];
			v[4] = v[4] + t1;
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
	endtask

	task automatic place_byte(int unsigned pos, logic [7:0] b);
		blk[pos / 8][(7 - pos % 8) * 8 +: 8] = b;
	endtask

	task automatic absorb_item(logic [7:0] b, logic has, logic fin);
		digest_item_t d;
		if (has) begin
			place_byte(byte_pos, b);
			bit_count += 8;
			byte_pos = (byte_pos + 1) % 128;
			if (byte_pos == 0) compress();
		end
		if (fin) begin
			place_byte(byte_pos, PAD_BYTE);
			for (int p = byte_pos + 1; p < 128; p++) place_byte(p, 8'h00);
			if (byte_pos >= LEN_POS) begin
				compress();
				for (int i = 0; i < 16; i++) blk[i] = '0;
			end
			blk[14] = '0;
			blk[15] = bit_count;
			compress();
			for (int i = 0; i < 8; i++) begin
				d.word = chain[i];
				d.num = i[2:0];
				d.last = (i == 7);
				digest_queue.push_back(d);
				chain[i] = INIT_H[i];
			end
			bit_count = '0;
			byte_pos = 0;
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++) chain[i] = INIT_H[i];
		for (int i = 0; i < 16; i++) blk[i] = '0;
		bit_count = '0;
		byte_pos = 0;
		errors = 0;
	end

	assign pending = digest_queue.size();

	always @(posedge clk) begin
		digest_item_t d;
		if (arst_n) begin
			if (in_valid && in_ready) absorb_item(data_byte, has_byte, end_of_message);
			if (out_valid && out_ready) begin
				if (digest_queue.size() == 0) begin
					errors++;
					$display("%0t: unexpected digest word %h num %0d", $time, digest_word,
						word_number);
				end else begin
					d = digest_queue.pop_front();
					if (d.word !== digest_word) begin
						errors++;
						$display("%0t: digest word %0d expected %h actual %h", $time, d.num,
							d.word, digest_word);
					end
					if (d.num !== word_number) begin
						errors++;
						$display("%0t: word number expected %0d actual %0d", $time, d.num,
							word_number);
					end
					if (d.last !== last_word) begin
						errors++;
						$display("%0t: last word expected %b actual %b", $time, d.last,
							last_word);
					end
				end
			end
		end
	end
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams directed and random messages of many lengths into the hash core,
// with random gaps and output stalls; the checker predicts every digest.
// ----------------------------------------------------------------------------
module testbench;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [7:0] data_byte;
	logic has_byte;
	logic end_of_message;
	logic out_valid;
	logic out_ready;
	logic [63:0] digest_word;
	logic [2:0] word_number;
	logic last_word;
	int errors;
	int pending;
	int idle_cycles;
	int sent;
	logic out_quiet;

	localparam int WATCHDOG = 20000;

	sha512_hash_core i_dut (.*);

	sha512_digest_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// stall the output side by a random count before each word, except in quiet spells
	initial begin
		int wait_n;
		out_ready = 0;
		out_quiet = 0;
		@(posedge arst_n);
		forever begin
			wait_n = out_quiet ? 0 : $urandom_range(0, 5);
			if (wait_n > 0) begin
				out_ready <= 0;
				repeat (wait_n) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if ($urandom_range(0, 7) == 0) out_quiet = ~out_quiet;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_item(logic [7:0] b, logic has, logic fin, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		data_byte <= b;
		has_byte <= has;
		end_of_message <= fin;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	// message of len bytes with occasional idle items mixed in
	task automatic send_message(int len, int pattern, bit empty_end);
		logic [7:0] b;
		bit burst;
		burst = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < len; i++) begin
			case (pattern)
				0: b = 8'h00;
				1: b = 8'hff;
				2: b = i[7:0];
				default: b = 8'($urandom_range(0, 255));
			endcase
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom_range(0, 255)), 0, 0, burst);
			send_item(b, 1, (!empty_end && i == len - 1), burst);
		end
		if (empty_end || len == 0) send_item(8'($urandom_range(0, 255)), 0, 1, burst);
	endtask

	initial begin
		int len;
		idle_cycles = 0;
		sent = 0;
		in_valid = 0;
		data_byte = 0;
		has_byte = 0;
		end_of_message = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// empty message, single byte, pad past the length field, full block with end
		send_message(0, 3, 1);
		send_message(1, 1, 0);
		send_item(8'h55, 0, 0, 0);
		send_message(3, 0, 1);
		send_message(112, 1, 0);
		send_message(128, 3, 0);
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat ($urandom_range(5, 40)) @(posedge clk);
		while (sent < 400) begin
			case ($urandom_range(0, 4))
				0: len = $urandom_range(0, 3);
				1: len = $urandom_range(108, 132);
				2: len = $urandom_range(236, 260);
				default: len = $urandom_range(0, 40);
			endcase
			if (len > 410 - sent) len = 410 - sent;
			send_message(len, $urandom_range(0, 5), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 9) == 0) begin
				in_valid <= 0;
				while (pending != 0) @(posedge clk);
			end
		end
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
